// File: rtl/two_class_fifo_oldest_first_macros.svh
// Assertion macros used by the two-class FIFO top level.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_MACROS_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TFO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TFO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tfo_pkg.sv
// Shared types and constants for the two-class FIFO with oldest-first dequeue.
package tfo_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int TagBitsDefault    = 16;
  localparam int InUserW           = 3;
  localparam int OutUserW          = 3;

  typedef enum logic [1:0] {
    CMD_ENQ      = 2'd0,
    CMD_TAKE_ANY = 2'd1,
    CMD_TAKE_C0  = 2'd2,
    CMD_TAKE_C1  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// File: rtl/two_class_fifo_oldest_first.sv
// Top level of the two-class FIFO with age-ordered dequeue.
//
// Commands arrive on the slave stream: tuser carries the command and the item
// class, tdata carries the item tag. Each command yields exactly one result
// transaction on the master stream: tuser carries the status and the class of
// the item handed out, tdata carries its tag.
// Enqueue stores the tag with an arrival stamp in its class queue, or reports
// full and drops it. Take-any hands out the older of the two heads by a
// wrap-aware stamp compare, class 0 winning a tie; take-class hands out the
// head of that class. A take from an empty source reports empty.
// Results are registered and appear in the cycle after the command; one
// command is taken every cycle unless a result waits. Each queue is a row of
// cells that shift toward the head on a dequeue, so no read pointer is needed.
// The result register is freed in the cycle the receiver takes it, so a
// stalled receiver holds the result and blocks new commands only while the
// result waits. Reset empties both queues and clears the stamp counter.
module two_class_fifo_oldest_first #(
  parameter int QUEUE_DEPTH = tfo_pkg::QueueDepthDefault,
  parameter int TAG_BITS    = tfo_pkg::TagBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // item_tag
  input  logic [((TAG_BITS+7)/8)*8-1:0]        s_axis_tdata,
  // command, item_class
  input  logic [tfo_pkg::InUserW-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // taken_tag
  output logic [((TAG_BITS+7)/8)*8-1:0]        m_axis_tdata,
  // status, taken_class
  output logic [tfo_pkg::OutUserW-1:0]         m_axis_tuser
);
  import tfo_pkg::*;

  localparam int StampMod  = 4 * QUEUE_DEPTH;
  localparam int StampHalf = 2 * QUEUE_DEPTH;
  localparam int StampW    = $clog2(StampMod);
  localparam int TdataW    = ((TAG_BITS + 7) / 8) * 8;
  localparam int EntryW    = TAG_BITS + StampW;

  logic                accept;
  cmd_e                cmd;
  logic                cls;
  logic [TAG_BITS-1:0] in_tag;

  q_ctrl_t             ctrl0;
  q_ctrl_t             ctrl1;
  q_stat_t             stat0;
  q_stat_t             stat1;
  logic [EntryW-1:0]   head0;
  logic [EntryW-1:0]   head1;
  logic [EntryW-1:0]   wr_entry;

  logic [StampW-1:0]   arrival_q;
  logic [StampW-1:0]   arrival_d;

  logic [StampW:0]     stamp_diff;
  logic [StampW:0]     stamp_dist;
  logic                c0_older;

  status_e             res_status;
  logic                res_class;
  logic [TAG_BITS-1:0] res_tag;

  logic                out_valid_q;
  logic                out_valid_d;
  status_e             status_q;
  logic                class_q;
  logic [TAG_BITS-1:0] tag_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser[1:0]);
  assign cls           = s_axis_tuser[2];
  assign in_tag        = s_axis_tdata[TAG_BITS-1:0];
  assign wr_entry      = {in_tag, arrival_q};

  assign stamp_diff = {1'b0, head1[StampW-1:0]} - {1'b0, head0[StampW-1:0]};
  assign stamp_dist = stamp_diff[StampW] ? stamp_diff + (StampW+1)'(StampMod) : stamp_diff;
  assign c0_older   = (stamp_dist < (StampW+1)'(StampHalf));

  always_comb begin
    logic take_ok;
    logic src;
    take_ok    = 1'b0;
    src        = 1'b0;
    ctrl0      = '0;
    ctrl1      = '0;
    res_status = ST_DONE;
    res_class  = 1'b0;
    res_tag    = '0;
    unique case (cmd)
      CMD_ENQ: begin
        if (cls) begin
          if (stat1.full) begin
            res_status = ST_FULL;
          end else begin
            ctrl1.push = accept;
          end
        end else begin
          if (stat0.full) begin
            res_status = ST_FULL;
          end else begin
            ctrl0.push = accept;
          end
        end
      end
      CMD_TAKE_ANY: begin
        priority if (!stat0.empty && !stat1.empty) begin
          take_ok = 1'b1;
          src     = !c0_older;
        end else if (!stat0.empty) begin
          take_ok = 1'b1;
          src     = 1'b0;
        end else if (!stat1.empty) begin
          take_ok = 1'b1;
          src     = 1'b1;
        end else begin
          take_ok = 1'b0;
        end
      end
      CMD_TAKE_C0: begin
        take_ok = !stat0.empty;
        src     = 1'b0;
      end
      CMD_TAKE_C1: begin
        take_ok = !stat1.empty;
        src     = 1'b1;
      end
    endcase
    if (cmd != CMD_ENQ) begin
      if (take_ok) begin
        res_class = src;
        if (src) begin
          ctrl1.pop = accept;
          res_tag   = head1[EntryW-1:StampW];
        end else begin
          ctrl0.pop = accept;
          res_tag   = head0[EntryW-1:StampW];
        end
      end else begin
        res_status = ST_EMPTY;
      end
    end
  end

  tfo_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .ENTRY_W(EntryW)
  ) u_queue0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl0),
    .wr_data_i(wr_entry),
    .stat_o   (stat0),
    .head_o   (head0)
  );

  tfo_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .ENTRY_W(EntryW)
  ) u_queue1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl1),
    .wr_data_i(wr_entry),
    .stat_o   (stat1),
    .head_o   (head1)
  );

  always_comb begin
    arrival_d = arrival_q;
    if (ctrl0.push || ctrl1.push) begin
      if (arrival_q == StampW'(StampMod - 1)) begin
        arrival_d = '0;
      end else begin
        arrival_d = arrival_q + StampW'(1);
      end
    end
  end

  assign out_valid_d = accept || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrival_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      arrival_q   <= arrival_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= res_status;
      class_q  <= res_class;
      tag_q    <= res_tag;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataW'(tag_q);
  assign m_axis_tuser  = {class_q, status_q};

`include "two_class_fifo_oldest_first_macros.svh"

  `TFO_ASSERT_SAME(a_no_push_with_pop, ctrl0.push || ctrl1.push, !ctrl0.pop && !ctrl1.pop, "Enqueue and dequeue in the same cycle.")
  `TFO_ASSERT_NEXT(a_stamp_advances, ctrl0.push || ctrl1.push, arrival_q != $past(arrival_q), "Arrival stamp did not advance on a stored enqueue.")
  `TFO_ASSERT_SAME(a_empty_result_clean, out_valid_q && status_q == ST_EMPTY, tag_q == '0 && !class_q, "Empty result carries a tag or class.")
  `TFO_ASSERT_SAME(a_queue_flags_exclusive, 1'b1, !(stat0.empty && stat0.full) && !(stat1.empty && stat1.full), "Queue reports empty and full together.")

endmodule

// File: rtl/tfo_cell.sv
// One storage cell of a class queue: loads a new entry or takes its neighbor's entry.
module tfo_cell #(
  parameter int ENTRY_W = 22
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               shift_i,
  input  logic [ENTRY_W-1:0] wr_data_i,
  input  logic [ENTRY_W-1:0] nb_data_i,
  output logic [ENTRY_W-1:0] data_o
);

  logic [ENTRY_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= wr_data_i;
    end else if (shift_i) begin
      data_q <= nb_data_i;
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/tfo_queue.sv
// Class queue built as a row of cells with the head always in the first cell.
module tfo_queue #(
  parameter int DEPTH   = 16,
  parameter int ENTRY_W = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfo_pkg::q_ctrl_t   ctrl_i,
  input  logic [ENTRY_W-1:0] wr_data_i,
  output tfo_pkg::q_stat_t   stat_o,
  output logic [ENTRY_W-1:0] head_o
);
  import tfo_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    count_d;
  logic [ENTRY_W-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] nb_data;
    if (i < DEPTH - 1) begin : g_mid
      assign nb_data = cell_data[i+1];
    end else begin : g_last
      assign nb_data = cell_data[i];
    end
    tfo_cell #(
      .ENTRY_W(ENTRY_W)
    ) u_cell (
      .clk_i    (clk_i),
      .load_i   (ctrl_i.push && (count_q == CntW'(i))),
      .shift_i  (ctrl_i.pop),
      .wr_data_i(wr_data_i),
      .nb_data_i(nb_data),
      .data_o   (cell_data[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign head_o       = cell_data[0];

endmodule
